// ===== rtl/core/cltw_pkg.sv =====
// Shared types, constants and address helper for the character LCD text writer.
package cltw_pkg;

  // Command codes on the input stream
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_MOVE  = 2'd1;
  localparam logic [1:0] CMD_HOME  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_I2C_ADDRESS  = 2'd0;
  localparam logic [1:0] REG_COLUMNS      = 2'd1;
  localparam logic [1:0] REG_ROWS         = 2'd2;
  localparam logic [1:0] REG_BACKLIGHT_ON = 2'd3;

  // Register reset values
  localparam logic [6:0] RST_I2C_ADDRESS  = 7'd39;
  localparam logic [5:0] RST_COLUMNS      = 6'd16;
  localparam logic [2:0] RST_ROWS         = 3'd2;
  localparam logic       RST_BACKLIGHT_ON = 1'b1;

  // LCD instruction codes
  localparam logic [7:0] OP_CLEAR     = 8'h01;
  localparam logic [7:0] OP_HOME      = 8'h02;
  localparam logic [7:0] OP_DDRAM     = 8'h80;
  localparam logic [7:0] ROW_ODD_BASE = 8'h40;
  localparam logic [7:0] NIB_MASK     = 8'hF0;

  // Default depth of the command queue between front and back
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Configuration as seen by the front and back
  typedef struct packed {
    logic [6:0] i2c_address;
    logic [5:0] columns;
    logic [2:0] rows;
    logic       backlight_on;
  } cfg_t;

  // One queued command: optional leading instruction, then the main byte
  typedef struct packed {
    logic       pre_valid;
    logic [7:0] pre_byte;
    logic [7:0] main_byte;
    logic       main_rs;
  } lcd_cmd_t;

  // DDRAM address for a cursor position, four-row layout, modulo 256
  function automatic logic [7:0] ddram_addr(input logic [1:0] row,
                                            input logic [5:0] col,
                                            input logic [5:0] columns);
    logic [7:0] a;
    begin
      case (row)
        2'd0:    a = {2'b00, col};
        2'd1:    a = ROW_ODD_BASE + {2'b00, col};
        2'd2:    a = {2'b00, columns} + {2'b00, col};
        default: a = ROW_ODD_BASE + {2'b00, columns} + {2'b00, col};
      endcase
      return a;
    end
  endfunction

endpackage

// ===== rtl/core/cltw_front.sv =====
// Front end: accepts commands, tracks the cursor and builds queued LCD byte pairs.
module cltw_front (
  input  logic                clk,
  input  logic                rst,
  input  cltw_pkg::cfg_t      cfg,
  input  logic                in_valid,
  input  logic [1:0]          cmd,
  input  logic [7:0]          char_code,
  input  logic [5:0]          target_col,
  input  logic [1:0]          target_row,
  input  logic                queue_full,
  output logic                in_ready,
  output logic                push,
  output cltw_pkg::lcd_cmd_t  push_cmd
);

  logic [5:0] cursor_col;
  logic [1:0] cursor_row;
  logic [5:0] cursor_col_next;
  logic [1:0] cursor_row_next;
  logic [1:0] wrap_row;
  logic       wrap;
  logic       on_last_row;

  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full;

  assign wrap        = cursor_col >= cfg.columns;
  assign on_last_row = ({1'b0, cursor_row} + 3'd1) >= cfg.rows;
  assign wrap_row    = cursor_row + 2'd1;

  // Classify the command and work out the new cursor
  always_comb begin
    cursor_col_next    = cursor_col;
    cursor_row_next    = cursor_row;
    push_cmd.pre_valid = 1'b0;
    push_cmd.pre_byte  = cltw_pkg::OP_HOME;
    push_cmd.main_byte = cltw_pkg::OP_HOME;
    push_cmd.main_rs   = 1'b0;
    case (cmd)
      cltw_pkg::CMD_WRITE: begin
        push_cmd.main_byte = char_code;
        push_cmd.main_rs   = 1'b1;
        cursor_col_next    = cursor_col + 6'd1;
        if (wrap) begin
          push_cmd.pre_valid = 1'b1;
          cursor_col_next    = 6'd1;
          if (on_last_row) begin
            push_cmd.pre_byte = cltw_pkg::OP_HOME;
            cursor_row_next   = 2'd0;
          end else begin
            push_cmd.pre_byte = cltw_pkg::OP_DDRAM
                              + cltw_pkg::ddram_addr(wrap_row, 6'd0, cfg.columns);
            cursor_row_next   = wrap_row;
          end
        end
      end
      cltw_pkg::CMD_MOVE: begin
        cursor_col_next    = target_col;
        cursor_row_next    = target_row;
        push_cmd.main_byte = cltw_pkg::OP_DDRAM
                           + cltw_pkg::ddram_addr(target_row, target_col, cfg.columns);
      end
      cltw_pkg::CMD_HOME: begin
        cursor_col_next    = 6'd0;
        cursor_row_next    = 2'd0;
        push_cmd.main_byte = cltw_pkg::OP_HOME;
      end
      default: begin
        cursor_col_next    = 6'd0;
        cursor_row_next    = 2'd0;
        push_cmd.main_byte = cltw_pkg::OP_CLEAR;
      end
    endcase
  end

  // Cursor state, updated on each accepted command
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= 6'd0;
      cursor_row <= 2'd0;
    end else if (push) begin
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
    end
  end

endmodule

// ===== rtl/core/cltw_queue.sv =====
// Short command queue between the front end and the byte serialiser.
module cltw_queue #(
  parameter int DEPTH = cltw_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  cltw_pkg::lcd_cmd_t  push_cmd,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output cltw_pkg::lcd_cmd_t  head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cltw_pkg::lcd_cmd_t store [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = count == CW'(DEPTH);
  assign not_empty = count != '0;
  assign head      = store[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/cltw_back.sv =====
// Back end: serialises each queued command into expander bytes, one per cycle while out_ready is high.
module cltw_back (
  input  logic                clk,
  input  logic                rst,
  input  cltw_pkg::cfg_t      cfg,
  input  logic                q_not_empty,
  input  cltw_pkg::lcd_cmd_t  q_head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          expander_byte,
  output logic [6:0]          bus_address,
  output logic                last
);

  cltw_pkg::lcd_cmd_t cur;
  logic       busy;
  // phase[2]: main byte, phase[1]: low nibble, phase[0]: enable low
  logic [2:0] phase;
  logic [7:0] sel_byte;
  logic [3:0] nib;
  logic       rs;
  logic       xfer;

  assign xfer      = busy && out_ready;
  assign last      = phase == 3'd7;
  assign pop       = q_not_empty && (!busy || (xfer && last));
  assign out_valid = busy;

  // Output byte from the current command and phase
  assign sel_byte      = phase[2] ? cur.main_byte : cur.pre_byte;
  assign nib           = phase[1] ? sel_byte[3:0] : sel_byte[7:4];
  assign rs            = phase[2] ? cur.main_rs : 1'b0;
  assign expander_byte = {nib, cfg.backlight_on, ~phase[0], 1'b0, rs};
  assign bus_address   = cfg.i2c_address;

  // Command register, phase counter and busy flag
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
    if (rst) begin
      busy  <= 1'b0;
      phase <= 3'd0;
    end else if (pop) begin
      busy  <= 1'b1;
      phase <= q_head.pre_valid ? 3'd0 : 3'd4;
    end else if (xfer) begin
      if (last) begin
        busy <= 1'b0;
      end
      phase <= phase + 3'd1;
    end
  end

endmodule

// ===== rtl/core/char_lcd_i2c_text_writer.sv =====
// Top level of the character LCD text writer: configuration registers and the datapath.
//
// Takes write-character, move, home and clear commands and emits the byte stream
// for an I2C port expander driving an HD44780-style LCD in 4-bit mode. Each command
// produces 4 expander bytes (8 for a character write that wraps), one per cycle on
// the master stream while it is ready, with tlast on the final byte. The output rate
// is set by the serialiser, which sends one expander byte per cycle while the
// receiver is ready; the front end takes a new command every cycle while the command
// queue has room. Configuration writes are always taken.
module char_lcd_i2c_text_writer #(
  parameter int QUEUE_DEPTH = cltw_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // Command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] cmd, [9:2] char_code, [15:10] target_col, [17:16] target_row, zero fill
  input  logic [23:0] s_axis_tdata,
  // Expander byte stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] expander_byte, [14:8] bus_address, [15] zero
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  cltw_pkg::cfg_t     cfg;
  cltw_pkg::lcd_cmd_t push_cmd;
  cltw_pkg::lcd_cmd_t q_head;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_not_empty;
  logic [7:0] expander_byte;
  logic [6:0] bus_address;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.i2c_address  <= cltw_pkg::RST_I2C_ADDRESS;
      cfg.columns      <= cltw_pkg::RST_COLUMNS;
      cfg.rows         <= cltw_pkg::RST_ROWS;
      cfg.backlight_on <= cltw_pkg::RST_BACKLIGHT_ON;
    end else if (cfg_valid) begin
      case (cfg_index)
        cltw_pkg::REG_I2C_ADDRESS: cfg.i2c_address  <= cfg_data;
        cltw_pkg::REG_COLUMNS:     cfg.columns      <= cfg_data[5:0];
        cltw_pkg::REG_ROWS:        cfg.rows         <= cfg_data[2:0];
        default:                   cfg.backlight_on <= cfg_data[0];
      endcase
    end
  end

  cltw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .cmd        (s_axis_tdata[1:0]),
    .char_code  (s_axis_tdata[9:2]),
    .target_col (s_axis_tdata[15:10]),
    .target_row (s_axis_tdata[17:16]),
    .queue_full (q_full),
    .in_ready   (s_axis_tready),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  cltw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  cltw_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_not_empty   (q_not_empty),
    .q_head        (q_head),
    .pop           (pop),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .expander_byte (expander_byte),
    .bus_address   (bus_address),
    .last          (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, bus_address, expander_byte};

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the character LCD text writer: commands in, expander bytes out.
`timescale 1ns / 100ps

module testbench;
  import cltw_pkg::*;

  // Expander byte control bits
  localparam logic [7:0] EXP_RS = 8'h01;
  localparam logic [7:0] EXP_EN = 8'h04;
  localparam logic [7:0] EXP_BL = 8'h08;

  localparam int STALL_LIMIT = 2000;  // cycles with no transfer anywhere
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] data;
    logic [6:0] addr;
    logic       last;
  } exp_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;

  // Predicted state and register copies
  logic [5:0] cur_col = '0;
  logic [1:0] cur_row = '0;
  logic [6:0] reg_addr = RST_I2C_ADDRESS;
  logic [5:0] reg_cols = RST_COLUMNS;
  logic [2:0] reg_rows = RST_ROWS;
  logic       reg_backlight = RST_BACKLIGHT_ON;

  exp_byte_t   pending_bytes[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  char_lcd_i2c_text_writer u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- prediction

  // One nibble: enable-high byte then enable-low byte, RS held on both
  function automatic void queue_nibble(logic [7:0] nib, logic rs, logic fin);
    exp_byte_t e;
    logic [7:0] base;
    base = (nib & NIB_MASK) | (rs ? EXP_RS : 8'h00) | (reg_backlight ? EXP_BL : 8'h00);
    e.addr = reg_addr;
    e.data = base | EXP_EN;
    e.last = 1'b0;
    pending_bytes.push_back(e);
    e.data = base;
    e.last = fin;
    pending_bytes.push_back(e);
  endfunction

  // LCD byte in 4-bit mode, high nibble first
  function automatic void queue_lcd_byte(logic [7:0] v, logic rs, logic fin);
    logic [7:0] low;
    low = v << 4;
    queue_nibble(v, rs, 1'b0);
    queue_nibble(low, rs, fin);
  endfunction

  // DDRAM address of the cursor, four-row layout, wraps at 8 bits
  function automatic logic [7:0] cursor_address();
    logic [7:0] c8;
    logic [7:0] w8;
    c8 = {2'b00, cur_col};
    w8 = {2'b00, reg_cols};
    case (cur_row)
      2'd0:    return c8;
      2'd1:    return ROW_ODD_BASE + c8;
      2'd2:    return w8 + c8;
      default: return ROW_ODD_BASE + w8 + c8;
    endcase
  endfunction

  function automatic void predict_expander_bytes(logic [1:0] cmd, logic [7:0] ch,
                                                 logic [5:0] col, logic [1:0] row);
    case (cmd)
      CMD_WRITE: begin
        // past the last column: next row, or home from the last row
        if (cur_col >= reg_cols) begin
          if (({1'b0, cur_row} + 3'd1) >= reg_rows) begin
            queue_lcd_byte(OP_HOME, 1'b0, 1'b0);
            cur_col = '0;
            cur_row = '0;
          end else begin
            cur_col = '0;
            cur_row = cur_row + 2'd1;
            queue_lcd_byte(OP_DDRAM + cursor_address(), 1'b0, 1'b0);
          end
        end
        queue_lcd_byte(ch, 1'b1, 1'b1);
        cur_col = cur_col + 6'd1;
      end
      CMD_MOVE: begin
        cur_col = col;
        cur_row = row;
        queue_lcd_byte(OP_DDRAM + cursor_address(), 1'b0, 1'b1);
      end
      CMD_HOME: begin
        queue_lcd_byte(OP_HOME, 1'b0, 1'b1);
        cur_col = '0;
        cur_row = '0;
      end
      default: begin
        queue_lcd_byte(OP_CLEAR, 1'b0, 1'b1);
        cur_col = '0;
        cur_row = '0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- receiver and checker

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      // check the transfer seen at this edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected byte %h addr %h last %b", $realtime,
                     m_axis_tdata[7:0], m_axis_tdata[14:8], m_axis_tlast);
        end else begin
          exp_byte_t e;
          e = pending_bytes.pop_front();
          if (m_axis_tdata[7:0] !== e.data || m_axis_tdata[14:8] !== e.addr ||
              m_axis_tlast !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: byte exp %h got %h, addr exp %h got %h, last exp %b got %b",
                       $realtime, e.data, m_axis_tdata[7:0], e.addr, m_axis_tdata[14:8],
                       e.last, m_axis_tlast);
          end
        end
      end
      // long hold-off first, random stalls otherwise
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus helpers

  // Leaves tvalid high so a back-to-back command needs no second assignment
  task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] ch,
                          input logic [5:0] col, input logic [1:0] row);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, row, col, ch, cmd};
    do @(posedge clk); while (!s_axis_tready);
    predict_expander_bytes(cmd, ch, col, row);
  endtask

  task automatic send_random_cmd();
    int unsigned r;
    logic [1:0] cmd;
    logic [5:0] col;
    r = $urandom_range(99);
    if (r < 58)      cmd = CMD_WRITE;
    else if (r < 78) cmd = CMD_MOVE;
    else if (r < 89) cmd = CMD_HOME;
    else             cmd = CMD_CLEAR;
    // moves often land near the end of a row to provoke wraps
    if ($urandom_range(1) == 1) col = reg_cols - 6'($urandom_range(2));
    else                        col = 6'($urandom_range(63));
    send_cmd(cmd, 8'($urandom_range(255)), col, 2'($urandom_range(3)));
  endtask

  // Sender pauses until every predicted byte has arrived
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [6:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_I2C_ADDRESS: reg_addr      = value;
      REG_COLUMNS:     reg_cols      = value[5:0];
      REG_ROWS:        reg_rows      = value[2:0];
      default:         reg_backlight = value[0];
    endcase
  endtask

  // All four registers, written only once the block has drained
  task automatic write_settings(input logic [6:0] addr, input logic [6:0] cols,
                                input logic [6:0] nrows, input logic [6:0] bl);
    wait_idle();
    cfg_write(REG_I2C_ADDRESS, addr);
    cfg_write(REG_COLUMNS, cols);
    cfg_write(REG_ROWS, nrows);
    cfg_write(REG_BACKLIGHT_ON, bl);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_random_settings();
    logic [5:0] cols;
    logic [2:0] nrows;
    case ($urandom_range(7))
      0:       cols = 6'd0;
      1:       cols = 6'd1;
      2:       cols = 6'($urandom_range(2, 4));
      3:       cols = 6'd40;
      4:       cols = 6'd63;
      default: cols = 6'($urandom_range(1, 40));
    endcase
    if ($urandom_range(3) == 0) nrows = 3'($urandom_range(7));
    else                        nrows = 3'($urandom_range(1, 4));
    write_settings(7'($urandom_range(127)), {1'($urandom_range(1)), cols},
                   {4'($urandom_range(15)), nrows}, 7'($urandom_range(127)));
  endtask

  // ---------------------------------------------------------------- tests

  // Every command at reset settings, field extremes, both kinds of wrap
  task automatic test_directed_commands();
    send_cmd(CMD_WRITE, 8'h00, 6'd0, 2'd0);
    send_cmd(CMD_WRITE, 8'hFF, 6'd63, 2'd3);
    send_cmd(CMD_WRITE, 8'hA5, 6'd0, 2'd0);
    send_cmd(CMD_MOVE, 8'h00, 6'd63, 2'd3);
    send_cmd(CMD_MOVE, 8'hFF, 6'd0, 2'd0);
    send_cmd(CMD_MOVE, 8'h00, 6'd39, 2'd1);
    send_cmd(CMD_MOVE, 8'h00, 6'd20, 2'd2);
    send_cmd(CMD_HOME, 8'hFF, 6'd63, 2'd3);
    send_cmd(CMD_CLEAR, 8'h5A, 6'd21, 2'd2);
    // wrap to the next row
    send_cmd(CMD_MOVE, 8'h00, 6'd15, 2'd0);
    send_cmd(CMD_WRITE, 8'h41, 6'd0, 2'd0);
    send_cmd(CMD_WRITE, 8'h42, 6'd0, 2'd0);
    // wrap from the last row homes
    send_cmd(CMD_MOVE, 8'h00, 6'd15, 2'd1);
    send_cmd(CMD_WRITE, 8'h43, 6'd0, 2'd0);
    send_cmd(CMD_WRITE, 8'h44, 6'd0, 2'd0);
  endtask

  task automatic test_register_corners();
    // zero columns and zero rows: every write homes first; backlight off
    write_settings(7'd0, 7'd0, 7'd0, 7'd0);
    send_cmd(CMD_WRITE, 8'h30, 6'd0, 2'd0);
    send_cmd(CMD_WRITE, 8'h31, 6'd0, 2'd0);
    send_cmd(CMD_MOVE, 8'h00, 6'd5, 2'd2);
    send_cmd(CMD_CLEAR, 8'h00, 6'd0, 2'd0);
    // largest values: address sum wraps at 8 bits, row wraps past 3
    write_settings(7'd127, 7'd63, 7'd7, 7'd1);
    send_cmd(CMD_MOVE, 8'h00, 6'd63, 2'd3);
    send_cmd(CMD_WRITE, 8'h7E, 6'd0, 2'd0);
    send_cmd(CMD_WRITE, 8'h7F, 6'd0, 2'd0);
    // columns lowered below the cursor
    write_settings(7'd39, 7'd40, 7'd4, 7'd1);
    send_cmd(CMD_MOVE, 8'h00, 6'd30, 2'd2);
    write_settings(7'd39, 7'd10, 7'd4, 7'd1);
    send_cmd(CMD_WRITE, 8'h55, 6'd0, 2'd0);
  endtask

  // Receiver holds off while commands keep coming, so the input must stall
  task automatic test_input_backpressure();
    write_settings(7'd39, 7'd20, 7'd4, 7'd1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left = HOLD_CYCLES;
    repeat (16) send_random_cmd();
    wait_idle();
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (2) begin
      write_random_settings();
      repeat (30) send_random_cmd();
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_commands();
    test_register_corners();
    test_input_backpressure();
    test_random_traffic(0, 0);
    test_random_traffic(54, 0);
    test_random_traffic(0, 54);
    test_random_traffic(31, 31);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
